@@ src/sgm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared widths, constants and the square root stage type of the Scharr gradient unit.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 512;
  localparam int FRAME_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int FRAME_ADDR_W = $clog2(FRAME_DEPTH);

  localparam int COL_W  = 9;
  localparam int ROW_W  = 9;
  localparam int SIZE_W = 10;
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 13;
  localparam int MAG_W  = 15;
  localparam int SQ_W   = 24;
  localparam int SUM_W  = 25;

  // integer square root of sum * 2^22, three result bits per stage
  localparam int RAD_W        = 48;
  localparam int ROOT_W       = 24;
  localparam int REM_W        = 27;
  localparam int SQRT_STAGES  = 8;
  localparam int SQRT_STEPS   = 3;

  // floor(root / 425) as (root * RECIP) >> RECIP_SHIFT, exact for 24-bit roots
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP = 25'd20211612;
  localparam int RECIP_SHIFT = 33;
  localparam int PROD_W      = ROOT_W + RECIP_W;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LAST  = 2'd3;

  typedef struct packed {
    logic                     vld;
    logic                     err;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
    logic [RAD_W-1:0]         rad;
  } sqrt_stage_t;

endpackage

@@ src/scharr_gradient_magnitude_wrap_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scharr_gradient_magnitude_wrap_unit
// Frame store with toroidal 3x3 Scharr gradient and scaled magnitude.
// ----------------------------------------------------------------------------
// Throughput: a compute word holds off further words until its last read
// phase, set by the eight neighbour reads on the two read ports of the frame
// memory; a load word every cycle while the sequencer and output are free.
// Reset: pipeline emptied, frame size back to 512 x 512; the frame store is
// not cleared and holds no data until written.
// ----------------------------------------------------------------------------
module scharr_gradient_magnitude_wrap_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // col[8:0], row[17:9], pixel[25:18]
  input  logic [0:0]  in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // grad_x[12:0], grad_y[25:13], magnitude[40:26]
  output logic [0:0]  out_tuser,  // error[0]
  input  logic        cfg_wen,
  input  logic [0:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  localparam int AW = sgm_pkg::FRAME_ADDR_W;
  localparam int CW = sgm_pkg::COL_W;
  localparam int RW = sgm_pkg::ROW_W;
  localparam int SW = sgm_pkg::SIZE_W;
  localparam int GW = sgm_pkg::GRAD_W;

  function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v, input int maxv);
    logic [SW-1:0] r;
    if (v == '0) r = SW'(1);
    else if (v > SW'(maxv)) r = SW'(maxv);
    else r = v;
    return r;
  endfunction

  function automatic logic [AW-1:0] pix_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(sgm_pkg::MAX_WIDTH) + AW'(c);
  endfunction

  // configuration
  logic [SW-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SW'(sgm_pkg::MAX_WIDTH);
      height_r <= SW'(sgm_pkg::MAX_HEIGHT);
    end else if (cfg_wen) begin
      unique case (cfg_addr[0])
        sgm_pkg::REG_FRAME_WIDTH:  width_r  <= clamp_size(cfg_wdata, sgm_pkg::MAX_WIDTH);
        sgm_pkg::REG_FRAME_HEIGHT: height_r <= clamp_size(cfg_wdata, sgm_pkg::MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  // global advance: the whole pipeline moves when the output slot frees
  logic adv;
  logic out_vld_r;
  assign adv = !out_vld_r || out_tready;

  // input decode
  logic [CW-1:0]           in_col;
  logic [RW-1:0]           in_row;
  logic [sgm_pkg::PIX_W-1:0] in_pix;
  logic                    in_oob, in_acc;
  assign in_col = in_tdata[8:0];
  assign in_row = in_tdata[17:9];
  assign in_pix = in_tdata[25:18];
  assign in_oob = ({1'b0, in_col} >= width_r) || ({1'b0, in_row} >= height_r);

  // read sequencer
  logic       busy_r, busy_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [CW-1:0] cl_r, c_r, cr_r;
  logic [RW-1:0] ru_r, r_r, rd_r;

  // an error word needs the issue slot, so it waits for an idle sequencer
  assign in_tready = adv && (!busy_r || (ph_r == sgm_pkg::PH_LAST && !in_oob));
  assign in_acc    = in_tvalid && in_tready;

  logic start;
  assign start = in_acc && !in_oob && in_tuser[0] == sgm_pkg::MODE_COMPUTE;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    if (adv) begin
      if (busy_r) begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == sgm_pkg::PH_LAST) busy_nxt = 1'b0;
      end
      if (start) begin
        busy_nxt = 1'b1;
        ph_nxt   = sgm_pkg::PH_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= sgm_pkg::PH_FIRST;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      c_r  <= in_col;
      r_r  <= in_row;
      cl_r <= (in_col == '0) ? CW'(width_r - SW'(1)) : in_col - CW'(1);
      cr_r <= ({1'b0, in_col} + SW'(1) >= width_r) ? '0 : in_col + CW'(1);
      ru_r <= (in_row == '0) ? RW'(height_r - SW'(1)) : in_row - RW'(1);
      rd_r <= ({1'b0, in_row} + SW'(1) >= height_r) ? '0 : in_row + RW'(1);
    end
  end

  // two neighbours per phase; the centre carries no weight
  logic [AW-1:0] ra, rb;
  always_comb begin
    unique case (ph_r)
      2'd0: begin ra = pix_addr(ru_r, cl_r); rb = pix_addr(ru_r, c_r);  end
      2'd1: begin ra = pix_addr(ru_r, cr_r); rb = pix_addr(r_r,  cl_r); end
      2'd2: begin ra = pix_addr(r_r,  cr_r); rb = pix_addr(rd_r, cl_r); end
      default: begin ra = pix_addr(rd_r, c_r); rb = pix_addr(rd_r, cr_r); end
    endcase
  end

  logic [sgm_pkg::PIX_W-1:0] pa, pb;

  sgm_ram #(
    .WIDTH (sgm_pkg::PIX_W),
    .DEPTH (sgm_pkg::FRAME_DEPTH)
  ) u_frame (
    .clk     (clk),
    .we      (in_acc && !in_oob && in_tuser[0] == sgm_pkg::MODE_LOAD),
    .waddr   (pix_addr(in_row, in_col)),
    .wdata   (in_pix),
    .re      (adv),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (pa),
    .rdata_b (pb)
  );

  // issue slot, lines up with the registered read data
  logic       iss_vld_r, iss_err_r;
  logic [1:0] iss_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_vld_r <= 1'b0;
      iss_err_r <= 1'b0;
      iss_ph_r  <= sgm_pkg::PH_FIRST;
    end else if (adv) begin
      iss_vld_r <= busy_r || (in_acc && in_oob);
      iss_err_r <= !busy_r;
      iss_ph_r  <= busy_r ? ph_r : sgm_pkg::PH_LAST;
    end
  end

  // accumulate gradients over the four phases
  logic signed [GW-1:0] gx_acc_r, gy_acc_r, gx_sum, gy_sum, a3, a10, b3, b10;
  assign a3  = GW'(signed'({1'b0, pa}) * 3);
  assign a10 = GW'(signed'({1'b0, pa}) * 10);
  assign b3  = GW'(signed'({1'b0, pb}) * 3);
  assign b10 = GW'(signed'({1'b0, pb}) * 10);

  always_comb begin
    gx_sum = (iss_ph_r == sgm_pkg::PH_FIRST) ? '0 : gx_acc_r;
    gy_sum = (iss_ph_r == sgm_pkg::PH_FIRST) ? '0 : gy_acc_r;
    unique case (iss_ph_r)
      2'd0: begin gx_sum = gx_sum + a3;        gy_sum = gy_sum + a3 + b10; end
      2'd1: begin gx_sum = gx_sum - a3 + b10;  gy_sum = gy_sum + a3;       end
      2'd2: begin gx_sum = gx_sum - a10 + b3;  gy_sum = gy_sum - b3;       end
      default: begin gx_sum = gx_sum - b3;     gy_sum = gy_sum - a10 - b3; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && iss_vld_r) begin
      gx_acc_r <= gx_sum;
      gy_acc_r <= gy_sum;
    end
  end

  // stage a: finished gradients
  logic a_vld_r, a_err_r;
  logic signed [GW-1:0] a_gx_r, a_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= iss_vld_r && iss_ph_r == sgm_pkg::PH_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_err_r <= iss_err_r;
      a_gx_r  <= iss_err_r ? '0 : gx_sum;
      a_gy_r  <= iss_err_r ? '0 : gy_sum;
    end
  end

  // stage b: squares
  logic b_vld_r, b_err_r;
  logic signed [GW-1:0] b_gx_r, b_gy_r;
  logic [sgm_pkg::SQ_W-1:0] b_sqx_r, b_sqy_r;
  logic signed [2*GW-1:0] sqx_full, sqy_full;
  assign sqx_full = a_gx_r * a_gx_r;
  assign sqy_full = a_gy_r * a_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_err_r <= a_err_r;
      b_gx_r  <= a_gx_r;
      b_gy_r  <= a_gy_r;
      b_sqx_r <= sqx_full[sgm_pkg::SQ_W-1:0];
      b_sqy_r <= sqy_full[sgm_pkg::SQ_W-1:0];
    end
  end

  // stage c: sum of squares
  logic c_vld_r, c_err_r;
  logic signed [GW-1:0] c_gx_r, c_gy_r;
  logic [sgm_pkg::SUM_W-1:0] c_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_err_r <= b_err_r;
      c_gx_r  <= b_gx_r;
      c_gy_r  <= b_gy_r;
      c_sum_r <= sgm_pkg::SUM_W'(b_sqx_r) + sgm_pkg::SUM_W'(b_sqy_r);
    end
  end

  // square root pipeline, restoring, one root bit per step
  sgm_pkg::sqrt_stage_t sq_r   [0:sgm_pkg::SQRT_STAGES-1];
  sgm_pkg::sqrt_stage_t sq_nxt [0:sgm_pkg::SQRT_STAGES-1];

  always_comb begin
    sgm_pkg::sqrt_stage_t st;
    logic [sgm_pkg::REM_W-1:0] rsh, trial;
    for (int k = 0; k < sgm_pkg::SQRT_STAGES; k++) begin
      if (k == 0) begin
        st.vld  = c_vld_r;
        st.err  = c_err_r;
        st.gx   = c_gx_r;
        st.gy   = c_gy_r;
        st.rem  = '0;
        st.root = '0;
        st.rad  = {1'b0, c_sum_r, 22'b0};
      end else begin
        st = sq_r[k-1];
      end
      for (int j = 0; j < sgm_pkg::SQRT_STEPS; j++) begin
        rsh   = {st.rem[sgm_pkg::REM_W-3:0], st.rad[sgm_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, st.root, 2'b01};
        st.rad = {st.rad[sgm_pkg::RAD_W-3:0], 2'b00};
        if (rsh >= trial) begin
          st.rem  = rsh - trial;
          st.root = {st.root[sgm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          st.rem  = rsh;
          st.root = {st.root[sgm_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      sq_nxt[k] = st;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < sgm_pkg::SQRT_STAGES; k++) begin
      if (!rst_n) begin
        sq_r[k].vld <= 1'b0;
      end else if (adv) begin
        sq_r[k] <= sq_nxt[k];
      end
    end
  end

  // stage d: reciprocal multiply for the divide by 425
  localparam int LS = sgm_pkg::SQRT_STAGES - 1;
  logic d_vld_r, d_err_r;
  logic signed [GW-1:0] d_gx_r, d_gy_r;
  logic [sgm_pkg::PROD_W-1:0] d_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= sq_r[LS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_err_r  <= sq_r[LS].err;
      d_gx_r   <= sq_r[LS].gx;
      d_gy_r   <= sq_r[LS].gy;
      d_prod_r <= sgm_pkg::PROD_W'(sq_r[LS].root) * sgm_pkg::PROD_W'(sgm_pkg::RECIP);
    end
  end

  // output register
  logic out_err_r;
  logic signed [GW-1:0] out_gx_r, out_gy_r;
  logic [sgm_pkg::MAG_W-1:0] out_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_err_r <= d_err_r;
      out_gx_r  <= d_gx_r;
      out_gy_r  <= d_gy_r;
      out_mag_r <= d_prod_r[sgm_pkg::RECIP_SHIFT +: sgm_pkg::MAG_W];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_err_r;
  assign out_tdata  = {7'b0, out_mag_r, out_gy_r, out_gx_r};

  // checks
  a_seq_busy : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && ph_r != sgm_pkg::PH_LAST |-> !in_tready)
    else $error("word accepted while neighbour reads in progress");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error word carries non-zero fields");

  a_mag_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[40:26] <= 15'd27805)
    else $error("magnitude beyond range");

endmodule

@@ src/sgm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_ram
// Generic RAM, one write port and two registered read ports with enable.
// ----------------------------------------------------------------------------
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ sim/tb_scharr_gradient_magnitude_wrap_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scharr_gradient_magnitude_wrap_unit
// Self-checking bench for the toroidal Scharr gradient unit. Loads pixels and
// requests gradients through the input stream and keeps its own frame copy,
// so each gradient and magnitude can be predicted and checked in order. Random
// gaps and back-pressure are applied on both sides, across several frame sizes.
// ----------------------------------------------------------------------------
module tb_scharr_gradient_magnitude_wrap_unit;

  localparam int ITEM_GOAL   = 1050;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 24;

  localparam int CW = sgm_pkg::COL_W;
  localparam int RW = sgm_pkg::ROW_W;
  localparam int PW = sgm_pkg::PIX_W;
  localparam int SW = sgm_pkg::SIZE_W;
  localparam int GW = sgm_pkg::GRAD_W;
  localparam int MW = sgm_pkg::MAG_W;

  typedef struct {
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
    logic [MW-1:0]        mag;
    logic                 err;
  } grad_res_t;

  typedef struct {
    bit            typed;   // expectation written in the row
    bit            is_cfg;
    logic          mode;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic [PW-1:0] pix;
    logic          reg_idx;
    logic [SW-1:0] reg_val;
    grad_res_t     res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_wen;
  logic [0:0]  cfg_addr;
  logic [9:0]  cfg_wdata;

  scharr_gradient_magnitude_wrap_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // local copy of the frame and which pixels hold data
  logic [PW-1:0] frame_copy [0:sgm_pkg::FRAME_DEPTH-1];
  bit            pix_written [0:sgm_pkg::FRAME_DEPTH-1];
  int unsigned   cur_w, cur_h;
  grad_res_t     grad_expected [$];

  int unsigned cycles, fails, n_words, n_results, n_grads, n_errs, n_phases;
  bit          no_idle;
  int          stall_left;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, grad_expected.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    grad_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (grad_expected.size() == 0) begin
        $error("result word with nothing expected: %h err %b", out_tdata, out_tuser);
        fails++;
      end else begin
        want = grad_expected.pop_front();
        if (out_tdata[12:0] !== want.gx) begin
          $error("grad_x: expected %0d, got %0d", want.gx, $signed(out_tdata[12:0]));
          fails++;
        end
        if (out_tdata[25:13] !== want.gy) begin
          $error("grad_y: expected %0d, got %0d", want.gy, $signed(out_tdata[25:13]));
          fails++;
        end
        if (out_tdata[40:26] !== want.mag) begin
          $error("magnitude: expected %0d, got %0d", want.mag, out_tdata[40:26]);
          fails++;
        end
        if (out_tuser[0] !== want.err) begin
          $error("error: expected %b, got %b", want.err, out_tuser[0]);
          fails++;
        end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned clamp_size(logic [SW-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int pix_at(int unsigned c, int unsigned r);
    return frame_copy[r * sgm_pkg::MAX_WIDTH + c];
  endfunction

  // update the frame copy and queue the expected word, if any
  task automatic predict_gradient(logic m, logic [CW-1:0] c, logic [RW-1:0] r,
                                  logic [PW-1:0] p);
    int unsigned cl, cr, ru, rd;
    int gx, gy;
    longint unsigned s, q;
    grad_res_t res;
    if (c >= cur_w || r >= cur_h) begin
      res = '{gx: '0, gy: '0, mag: '0, err: 1'b1};
      grad_expected.push_back(res);
      n_errs++;
    end else if (m == sgm_pkg::MODE_LOAD) begin
      frame_copy[r * sgm_pkg::MAX_WIDTH + c] = p;
      pix_written[r * sgm_pkg::MAX_WIDTH + c] = 1'b1;
    end else begin
      cl = (c == 0) ? cur_w - 1 : c - 1;
      cr = (c + 1 >= cur_w) ? 0 : c + 1;
      ru = (r == 0) ? cur_h - 1 : r - 1;
      rd = (r + 1 >= cur_h) ? 0 : r + 1;
      gx = 3 * pix_at(cl, ru) + 10 * pix_at(cl, r) + 3 * pix_at(cl, rd)
         - 3 * pix_at(cr, ru) - 10 * pix_at(cr, r) - 3 * pix_at(cr, rd);
      gy = 3 * pix_at(cl, ru) + 10 * pix_at(c, ru) + 3 * pix_at(cr, ru)
         - 3 * pix_at(cl, rd) - 10 * pix_at(c, rd) - 3 * pix_at(cr, rd);
      s = longint'(gx * gx) + longint'(gy * gy);
      q = int_sqrt(s * 64'd4194304) / 425;
      if (q > 'h7FFF) q = 'h7FFF;
      res = '{gx: gx[GW-1:0], gy: gy[GW-1:0], mag: q[MW-1:0], err: 1'b0};
      grad_expected.push_back(res);
      n_grads++;
    end
  endtask

  task automatic drive_word(logic m, logic [CW-1:0] c, logic [RW-1:0] r,
                            logic [PW-1:0] p);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata  <= {6'd0, p, r, c};
    in_tuser  <= m;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_words++;
  endtask

  task automatic send_word(logic m, logic [CW-1:0] c, logic [RW-1:0] r,
                           logic [PW-1:0] p);
    predict_gradient(m, c, r, p);
    drive_word(m, c, r, p);
  endtask

  // drop valid, let every expected word arrive, then cover load-only latency
  task automatic settle();
    in_tvalid <= 1'b0;
    while (grad_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // drive the write, then drop the enable so back to back writes never overlap
  task automatic write_reg(logic idx, logic [SW-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
    if (idx == sgm_pkg::REG_FRAME_WIDTH) cur_w = clamp_size(val, sgm_pkg::MAX_WIDTH);
    else cur_h = clamp_size(val, sgm_pkg::MAX_HEIGHT);
  endtask

  // make sure all nine pixels around (c,r) hold data, then ask for the gradient
  task automatic compute_at(int unsigned c, int unsigned r);
    int unsigned nc, nr;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nc = (int'(c) + dc + int'(cur_w)) % cur_w;
        nr = (int'(r) + dr + int'(cur_h)) % cur_h;
        if (!pix_written[nr * sgm_pkg::MAX_WIDTH + nc])
          send_word(sgm_pkg::MODE_LOAD, CW'(nc), RW'(nr), PW'($urandom_range(0, 255)));
      end
    end
    send_word(sgm_pkg::MODE_COMPUTE, CW'(c), RW'(r), PW'($urandom_range(0, 255)));
  endtask

  localparam grad_res_t ERR_RES = '{gx: '0, gy: '0, mag: '0, err: 1'b1};
  localparam grad_res_t NO_RES  = '{gx: '0, gy: '0, mag: '0, err: 1'b0};

  stim_row_t directed [] = '{
    // strong edge at the wrapped corner: left column and upper row bright
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd511, 9'd511, 8'd255, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd0,   9'd511, 8'd255, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd1,   9'd511, 8'd255, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd511, 9'd0,   8'd255, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd0,   9'd0,   8'd128, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd1,   9'd0,   8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd511, 9'd1,   8'd255, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd0,   9'd1,   8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd1,   9'd1,   8'd0,   0, 0, NO_RES},
    // rest of the neighbourhoods around (511,0) and (1,511)
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd510, 9'd511, 8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd510, 9'd0,   8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd510, 9'd1,   8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd0,   9'd510, 8'd255, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd1,   9'd510, 8'd255, 0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd2,   9'd510, 8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd2,   9'd511, 8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_LOAD, 9'd2,   9'd0,   8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_COMPUTE, 9'd0, 9'd0,  8'd0,   0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_COMPUTE, 9'd511, 9'd0, 8'd0,  0, 0, NO_RES},
    '{0, 0, sgm_pkg::MODE_COMPUTE, 9'd1, 9'd511, 8'd0,  0, 0, NO_RES},
    '{0, 1, sgm_pkg::MODE_LOAD, 0, 0, 0, sgm_pkg::REG_FRAME_WIDTH,  10'd2,   NO_RES},
    '{0, 1, sgm_pkg::MODE_LOAD, 0, 0, 0, sgm_pkg::REG_FRAME_HEIGHT, 10'd2,   NO_RES},
    '{1, 0, sgm_pkg::MODE_LOAD,    9'd2,   9'd0,   8'd77,  0, 0, ERR_RES},
    '{1, 0, sgm_pkg::MODE_COMPUTE, 9'd0,   9'd2,   8'd0,   0, 0, ERR_RES},
    '{1, 0, sgm_pkg::MODE_COMPUTE, 9'd511, 9'd511, 8'd255, 0, 0, ERR_RES},
    '{0, 0, sgm_pkg::MODE_COMPUTE, 9'd1,   9'd1,   8'd0,   0, 0, NO_RES},
    // zero reads as one: single pixel frame gives no gradient
    '{0, 1, sgm_pkg::MODE_LOAD, 0, 0, 0, sgm_pkg::REG_FRAME_WIDTH,  10'd0,   NO_RES},
    '{0, 1, sgm_pkg::MODE_LOAD, 0, 0, 0, sgm_pkg::REG_FRAME_HEIGHT, 10'd0,   NO_RES},
    '{0, 0, sgm_pkg::MODE_COMPUTE, 9'd0,   9'd0,   8'd0,   0, 0, NO_RES},
    '{1, 0, sgm_pkg::MODE_COMPUTE, 9'd1,   9'd0,   8'd0,   0, 0, ERR_RES}
  };

  int unsigned phase_w [] = '{5, 512, 1, 0, 1023, 3, 17, 2, 512, 7, 600};
  int unsigned phase_h [] = '{4, 1, 512, 600, 0, 3, 9, 2, 512, 6, 1};

  initial begin
    int unsigned phase_words, c, r, k, wv, hv;
    cycles = 0; fails = 0; n_words = 0; n_results = 0; n_grads = 0; n_errs = 0;
    n_phases = 0; no_idle = 1'b0;
    cur_w = sgm_pkg::MAX_WIDTH;
    cur_h = sgm_pkg::MAX_HEIGHT;
    foreach (pix_written[i]) pix_written[i] = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_wen   <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else if (directed[i].typed) begin
        grad_expected.push_back(directed[i].res);
        n_errs++;
        drive_word(directed[i].mode, directed[i].col, directed[i].row, directed[i].pix);
      end else begin
        send_word(directed[i].mode, directed[i].col, directed[i].row, directed[i].pix);
      end
    end

    while (n_words < ITEM_GOAL) begin
      settle();
      if (n_phases < phase_w.size()) begin
        wv = phase_w[n_phases];
        hv = phase_h[n_phases];
      end else begin
        wv = $urandom_range(1, 24);
        hv = $urandom_range(1, 24);
      end
      write_reg(sgm_pkg::REG_FRAME_WIDTH, SW'(wv));
      write_reg(sgm_pkg::REG_FRAME_HEIGHT, SW'(hv));
      no_idle = ($urandom_range(0, 3) == 0);
      n_phases++;
      phase_words = n_words + 110;
      while (n_words < phase_words && n_words < ITEM_GOAL) begin
        k = $urandom_range(0, 99);
        c = $urandom_range(0, cur_w - 1);
        r = $urandom_range(0, cur_h - 1);
        if (k < 15 && (cur_w < sgm_pkg::MAX_WIDTH || cur_h < sgm_pkg::MAX_HEIGHT)) begin
          // coordinate past the frame edge, either kind of word
          if (cur_w < sgm_pkg::MAX_WIDTH &&
              (cur_h == sgm_pkg::MAX_HEIGHT || $urandom_range(0, 1))) begin
            c = $urandom_range(cur_w, 511);
            r = $urandom_range(0, 511);
          end else begin
            c = $urandom_range(0, 511);
            r = $urandom_range(cur_h, 511);
          end
          send_word(1'($urandom_range(0, 1)), CW'(c), RW'(r), PW'($urandom_range(0, 255)));
        end else if (k < 55) begin
          send_word(sgm_pkg::MODE_LOAD, CW'(c), RW'(r), PW'($urandom_range(0, 255)));
        end else begin
          compute_at(c, r);
        end
      end
    end

    settle();
    $display("%0d words sent over %0d frame sizes, %0d cycles", n_words, n_phases + 3, cycles);
    $display("%0d result words: %0d gradients, %0d coordinate errors", n_results, n_grads,
             n_errs);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
